// ----- hdl/ort_pkg.sv -----
// ---------------------------------------------------------------------------
// ort_pkg
// Shared types, codes and sizes for the ordered record table.
// ---------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

   // sizes
   localparam int CAPACITY_DEFAULT = 128;
   localparam int NAME_W           = 64;
   localparam int COORD_W          = 32;
   localparam int OP_W             = 3;
   localparam int STATUS_W         = 2;
   localparam int COUNT_OUT_W      = 8;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam op_type OP_INSERT     = 3'd0;
   localparam op_type OP_DEL_NAME   = 3'd1;
   localparam op_type OP_DEL_COORD  = 3'd2;
   localparam op_type OP_FIND_NAME  = 3'd3;
   localparam op_type OP_FIND_COORD = 3'd4;

   // status codes
   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_FULL = 2'd1;
   localparam status_type ST_MISS = 2'd2;

   // one stored record
   typedef struct packed {
      logic        [NAME_W-1:0]  name;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } record_type;

   // what the compare unit looks for
   typedef struct packed {
      logic                      by_name;
      logic        [NAME_W-1:0]  name;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } probe_type;

endpackage

`default_nettype wire

// ----- hdl/ort_ifs.sv -----
// ---------------------------------------------------------------------------
// ort_ifs
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
`default_nettype none

interface ort_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ort_pkg::OP_W-1:0]       op;
   logic        [ort_pkg::NAME_W-1:0]     key_name;
   logic signed [ort_pkg::COORD_W-1:0]    coord_x;
   logic signed [ort_pkg::COORD_W-1:0]    coord_y;

   modport source (output valid, op, key_name, coord_x, coord_y, input ready);
   modport sink   (input valid, op, key_name, coord_x, coord_y, output ready);
endinterface

interface ort_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ort_pkg::STATUS_W-1:0]   status;
   logic        [ort_pkg::NAME_W-1:0]     hit_name;
   logic signed [ort_pkg::COORD_W-1:0]    hit_x;
   logic signed [ort_pkg::COORD_W-1:0]    hit_y;
   logic        [ort_pkg::COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, hit_name, hit_x, hit_y, entry_count,
                   input ready);
   modport sink   (input valid, status, hit_name, hit_x, hit_y, entry_count,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/ordered_record_table_unit.sv -----
// Ordered record table. Holds up to CAPACITY records (64-bit name key,
// signed 32-bit x and y) in insertion order and answers one request word
// at a time with exactly one response word. Insert and unused op codes
// show their response in the cycle after acceptance. Search and delete
// scan the table from the front, reading and then comparing each entry
// tested, and a delete then moves each later entry down, reading it and
// then writing it. The entries tested and the entries moved together
// never exceed the count. The pace of the scan is set by the one read
// port of the record memory, with its registered data, and the one shared
// compare unit. The request side is not ready from acceptance until the
// response word is taken.
// ---------------------------------------------------------------------------
// ordered_record_table_unit
// Top level: sequencer, shared compare unit and record memory.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_record_table_unit #(
   parameter int CAPACITY = ort_pkg::CAPACITY_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   ort_req_if.sink   req_bus,
   ort_rsp_if.source rsp_bus
);
   import ort_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   probe_type     probe;
   logic          hit;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   record_type    wr_data;
   logic [AW-1:0] rd_addr;
   record_type    rd_data;

   // control
   ort_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .probe   (probe),
      .hit     (hit),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare
   ort_match u_match (
      .probe (probe),
      .rec   (rd_data),
      .hit   (hit)
   );

   // storage
   ort_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ----- hdl/ort_store.sv -----
// ---------------------------------------------------------------------------
// ort_store
// Record memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ort_store #(
   parameter int CAPACITY = ort_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  ort_pkg::record_type              wr_data,
   input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
   output ort_pkg::record_type              rd_data
);
   import ort_pkg::*;

   record_type rec_mem_ff [CAPACITY];
   record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data registered, in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= rec_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/ort_match.sv -----
// ---------------------------------------------------------------------------
// ort_match
// Shared compare unit: tests one stored record against the probe key.
// ---------------------------------------------------------------------------
`default_nettype none

module ort_match (
   input  ort_pkg::probe_type  probe,
   input  ort_pkg::record_type rec,
   output logic                hit
);
   import ort_pkg::*;

   logic name_eq;
   logic coord_eq;

   // name match needs all key bits, coordinate match needs both axes
   assign name_eq  = (rec.name == probe.name);
   assign coord_eq = (rec.x == probe.x) && (rec.y == probe.y);
   assign hit      = probe.by_name ? name_eq : coord_eq;

endmodule

`default_nettype wire

// ----- hdl/ort_seq.sv -----
// ---------------------------------------------------------------------------
// ort_seq
// Sequencer: scans the table one entry at a time and shifts entries down
// after a delete, then presents one response word.
// ---------------------------------------------------------------------------
`default_nettype none

module ort_seq #(
   parameter int CAPACITY = ort_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ort_req_if.sink                          req_bus,
   ort_rsp_if.source                        rsp_bus,
   output ort_pkg::probe_type               probe,
   input  wire logic                        hit,
   output logic                             wr_en,
   output logic [$clog2(CAPACITY)-1:0]      wr_addr,
   output ort_pkg::record_type              wr_data,
   output logic [$clog2(CAPACITY)-1:0]      rd_addr,
   input  ort_pkg::record_type              rd_data
);
   import ort_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_SHRD = 3'd3;
   localparam logic [2:0] S_SHWR = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0]                state_ff, state_in;
   op_type                    op_ff, op_in;
   probe_type                 probe_ff, probe_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   status_type                status_ff, status_in;
   record_type                hit_rec_ff, hit_rec_in;

   logic                      req_acc;
   logic [CW-1:0]             idx_plus1;
   logic [CW-1:0]             idx_plus2;
   logic                      is_delete;
   record_type                new_rec;

   assign req_acc   = req_bus.valid && req_bus.ready;
   assign idx_plus1 = CW'(idx_ff) + CW'(1);
   assign idx_plus2 = CW'(idx_ff) + CW'(2);
   assign is_delete = (op_ff == OP_DEL_NAME) || (op_ff == OP_DEL_COORD);

   assign new_rec.name = req_bus.key_name;
   assign new_rec.x    = req_bus.coord_x;
   assign new_rec.y    = req_bus.coord_y;

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      probe_in   = probe_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      hit_rec_in = hit_rec_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      rd_addr    = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in            = req_bus.op;
               probe_in.by_name = (req_bus.op == OP_DEL_NAME) ||
                                  (req_bus.op == OP_FIND_NAME);
               probe_in.name    = req_bus.key_name;
               probe_in.x       = req_bus.coord_x;
               probe_in.y       = req_bus.coord_y;
               idx_in           = '0;
               hit_rec_in       = '0;
               status_in        = ST_MISS;
               state_in         = S_RESP;
               if (req_bus.op == OP_INSERT) begin
                  if (count_ff < CAP_COUNT) begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[AW-1:0];
                     wr_data   = new_rec;
                     count_in  = count_ff + CW'(1);
                     status_in = ST_DONE;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else if (req_bus.op inside {OP_DEL_NAME, OP_DEL_COORD,
                                               OP_FIND_NAME, OP_FIND_COORD}) begin
                  if (count_ff != '0) begin
                     state_in = S_READ;
                  end
               end
            end
         end

         // address the entry under test
         S_READ: begin
            rd_addr  = idx_ff;
            state_in = S_CMP;
         end

         // compare the entry just read
         S_CMP: begin
            if (hit) begin
               status_in = ST_DONE;
               if (is_delete) begin
                  if (idx_plus1 < count_ff) begin
                     state_in = S_SHRD;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = S_RESP;
                  end
               end else begin
                  hit_rec_in = rd_data;
                  state_in   = S_RESP;
               end
            end else if (idx_plus1 < count_ff) begin
               idx_in   = idx_plus1[AW-1:0];
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end

         // fetch the entry that moves down
         S_SHRD: begin
            rd_addr  = idx_plus1[AW-1:0];
            state_in = S_SHWR;
         end

         // move it one place down
         S_SHWR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = idx_plus1[AW-1:0];
            if (idx_plus2 < count_ff) begin
               state_in = S_SHRD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      probe_ff   <= probe_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      hit_rec_ff <= hit_rec_in;
   end

   assign probe               = probe_ff;
   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = (state_ff == S_RESP);
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.hit_name    = hit_rec_ff.name;
   assign rsp_bus.hit_x       = hit_rec_ff.x;
   assign rsp_bus.hit_y       = hit_rec_ff.y;
   assign rsp_bus.entry_count = COUNT_OUT_W'(count_ff);

endmodule

`default_nettype wire

// ----- hdl/ort_checker.sv -----
// ---------------------------------------------------------------------------
// ort_checker
// Port-level assertions for the ordered record table, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module ort_checker #(
   parameter int CAPACITY = ort_pkg::CAPACITY_DEFAULT
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [ort_pkg::OP_W-1:0]          req_op,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [ort_pkg::STATUS_W-1:0]      status,
   input wire logic [ort_pkg::NAME_W-1:0]        hit_name,
   input wire logic [ort_pkg::COORD_W-1:0]       hit_x,
   input wire logic [ort_pkg::COORD_W-1:0]       hit_y,
   input wire logic [ort_pkg::COUNT_OUT_W-1:0]   entry_count
);
   import ort_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   op_type     op_ff;
   logic [COUNT_OUT_W-1:0] last_cnt_ff;
   logic       no_hit_op;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign no_hit_op = (op_ff == OP_INSERT) || (op_ff == OP_DEL_NAME) ||
                      (op_ff == OP_DEL_COORD);

   // op of the word in flight and count from the last response
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_INSERT;
         last_cnt_ff <= '0;
      end else begin
         if (req_acc) begin
            op_ff <= req_op;
         end
         if (rsp_acc) begin
            last_cnt_ff <= entry_count;
         end
      end
   end

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(entry_count) && $stable(hit_name))
      else $error("response word changed while stalled");

   // one word in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while another is in flight");

   // a full or missed operation leaves the count alone
   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_DONE |-> entry_count == last_cnt_ff)
      else $error("count moved on a failed operation");

   // hit fields are zero unless a search found something
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_DONE || no_hit_op) |->
      hit_name == '0 && hit_x == '0 && hit_y == '0)
      else $error("hit fields set without a search hit");

   // full is only reported for an insert into a full table
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |->
      op_ff == OP_INSERT && entry_count == COUNT_OUT_W'(CAPACITY))
      else $error("full reported with room left");

endmodule

bind ordered_record_table_unit ort_checker #(
   .CAPACITY (CAPACITY)
) u_ort_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_op      (req_bus.op),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .status      (rsp_bus.status),
   .hit_name    (rsp_bus.hit_name),
   .hit_x       (rsp_bus.hit_x),
   .hit_y       (rsp_bus.hit_y),
   .entry_count (rsp_bus.entry_count)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives request words into the table and checks each response word
// against its typed directed row or a behavioral copy of the table kept
// here. A short table of directed words comes first, then random fill and
// drain with random stalls on both channels and one long response hold-off.
// ---------------------------------------------------------------------------

module testbench;
   import ort_pkg::*;

   localparam int TABLE_DEPTH  = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 16;

   // op codes the block ignores
   localparam op_type OP_UNUSED_LO = 3'd5;
   localparam op_type OP_UNUSED_HI = 3'd7;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
   localparam logic        [NAME_W-1:0]  NAME_ONES = '1;

   typedef struct {
      status_type                status;
      logic        [NAME_W-1:0]  name;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COUNT_OUT_W-1:0]    count;
   } reply_word_type;

   typedef struct {
      op_type                    op;
      logic        [NAME_W-1:0]  key;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      bit                        typed;
      reply_word_type            want;
   } stim_row_type;

   logic clock;
   logic reset;

   ort_req_if req_bus ();
   ort_rsp_if rsp_bus ();

   ordered_record_table_unit #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // copy of the table kept alongside the block
   record_type     shadow_records [TABLE_DEPTH];
   int             stored_count;
   reply_word_type awaited_replies[$];
   stim_row_type   directed_rows[$];

   int  error_count;
   int  cycle_count;
   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  hold_off_pending;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // apply one request word to the shadow table, return the reply word
   function automatic reply_word_type apply_to_table(op_type op, logic [NAME_W-1:0] key,
                                                     logic signed [COORD_W-1:0] x,
                                                     logic signed [COORD_W-1:0] y);
      reply_word_type r;
      int             pos;
      bit             by_name;
      r.status = ST_MISS;
      r.name   = '0;
      r.x      = '0;
      r.y      = '0;
      pos      = -1;
      by_name  = (op == OP_DEL_NAME) || (op == OP_FIND_NAME);
      case (op)
         OP_INSERT: begin
            if (stored_count < TABLE_DEPTH) begin
               shadow_records[stored_count].name = key;
               shadow_records[stored_count].x    = x;
               shadow_records[stored_count].y    = y;
               stored_count++;
               r.status = ST_DONE;
            end else begin
               r.status = ST_FULL;
            end
         end
         OP_DEL_NAME, OP_DEL_COORD, OP_FIND_NAME, OP_FIND_COORD: begin
            // first match in table order
            for (int i = 0; i < stored_count; i++) begin
               if (pos < 0) begin
                  if (by_name ? (shadow_records[i].name == key)
                              : (shadow_records[i].x == x && shadow_records[i].y == y))
                     pos = i;
               end
            end
            if (pos >= 0) begin
               r.status = ST_DONE;
               if (op == OP_FIND_NAME || op == OP_FIND_COORD) begin
                  r.name = shadow_records[pos].name;
                  r.x    = shadow_records[pos].x;
                  r.y    = shadow_records[pos].y;
               end else begin
                  // close the gap, keeping order
                  for (int j = pos; j < stored_count - 1; j++)
                     shadow_records[j] = shadow_records[j + 1];
                  stored_count--;
               end
            end
         end
         default: ;
      endcase
      r.count = stored_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic void add_row(op_type op, logic [NAME_W-1:0] key,
                                   logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y, bit typed,
                                   status_type st, logic [NAME_W-1:0] hn,
                                   logic signed [COORD_W-1:0] hx,
                                   logic signed [COORD_W-1:0] hy,
                                   logic [COUNT_OUT_W-1:0] cnt);
      stim_row_type row;
      row.op          = op;
      row.key         = key;
      row.x           = x;
      row.y           = y;
      row.typed       = typed;
      row.want.status = st;
      row.want.name   = hn;
      row.want.x      = hx;
      row.want.y      = hy;
      row.want.count  = cnt;
      directed_rows.push_back(row);
   endfunction

   // names: a few fixed keys for collisions, the rest fully random
   function automatic logic [NAME_W-1:0] pick_name();
      if ($urandom_range(99) < 40)
         return {$urandom, $urandom};
      case ($urandom_range(5))
         0:       return '0;
         1:       return NAME_ONES;
         2:       return 64'h616c_7068_6100_0000;
         3:       return 64'h6265_7461_0000_0000;
         4:       return 64'h0000_0000_0000_0041;
         default: return 64'h8000_0000_0000_0001;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      if ($urandom_range(1))
         return $urandom;
      case ($urandom_range(3))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         default: return $signed($urandom_range(6)) - 3;
      endcase
   endfunction

   // one request word: random gap, then hold until accepted
   task automatic send_word(stim_row_type row);
      reply_word_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= row.op;
      req_bus.key_name <= row.key;
      req_bus.coord_x  <= row.x;
      req_bus.coord_y  <= row.y;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_to_table(row.op, row.key, row.x, row.y);
      awaited_replies.push_back(row.typed ? row.want : predicted);
   endtask

   // response side: random stalls, and one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      reply_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_replies.size() == 0) begin
            $error("response word with none expected");
            error_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.hit_name !== want.name) begin
               $error("hit_name: expected %h, got %h", want.name, rsp_bus.hit_name);
               error_count++;
            end
            if (rsp_bus.hit_x !== want.x) begin
               $error("hit_x: expected %0d, got %0d", want.x, rsp_bus.hit_x);
               error_count++;
            end
            if (rsp_bus.hit_y !== want.y) begin
               $error("hit_y: expected %0d, got %0d", want.y, rsp_bus.hit_y);
               error_count++;
            end
            if (rsp_bus.entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count,
                      rsp_bus.entry_count);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type row;
      int           total_items;
      int           item_index;
      int           phase;
      int           roll;
      int           pick;
      bit           filling;
      int           overfill_left;

      error_count      = 0;
      stored_count     = 0;
      hold_off_pending = 1'b0;
      req_idle_pct     = 24;
      rsp_idle_pct     = 66;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_INSERT;
      req_bus.key_name = '0;
      req_bus.coord_x  = '0;
      req_bus.coord_y  = '0;
      reset            = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words: empty table, extremes, duplicates, first match, shifts
      add_row(OP_FIND_NAME, '0, 0, 0, 1, ST_MISS, '0, 0, 0, 0);
      add_row(OP_DEL_COORD, '0, 0, 0, 1, ST_MISS, '0, 0, 0, 0);
      add_row(OP_DEL_NAME, NAME_ONES, 0, 0, 1, ST_MISS, '0, 0, 0, 0);
      add_row(OP_UNUSED_HI, NAME_ONES, -1, -1, 1, ST_MISS, '0, 0, 0, 0);
      add_row(OP_INSERT, NAME_ONES, COORD_MIN, COORD_MAX, 1, ST_DONE, '0, 0, 0, 1);
      add_row(OP_INSERT, '0, COORD_MAX, COORD_MIN, 1, ST_DONE, '0, 0, 0, 2);
      add_row(OP_INSERT, 64'h41, 0, -1, 1, ST_DONE, '0, 0, 0, 3);
      add_row(OP_INSERT, '0, 5, 5, 1, ST_DONE, '0, 0, 0, 4);
      add_row(OP_FIND_NAME, '0, 0, 0, 1, ST_DONE, '0, COORD_MAX, COORD_MIN, 4);
      add_row(OP_FIND_COORD, '0, COORD_MIN, COORD_MAX, 1, ST_DONE, NAME_ONES,
              COORD_MIN, COORD_MAX, 4);
      add_row(OP_FIND_NAME, 64'h42, 0, 0, 1, ST_MISS, '0, 0, 0, 4);
      // x matches an entry, y does not
      add_row(OP_FIND_COORD, '0, COORD_MAX, COORD_MAX, 1, ST_MISS, '0, 0, 0, 4);
      add_row(OP_UNUSED_LO, '0, 5, 5, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_UNUSED_HI - op_type'(1), 64'h41, 0, -1, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_DEL_NAME, '0, 1, 1, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_FIND_NAME, '0, 0, 0, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_DEL_COORD, NAME_ONES, 0, -1, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_DEL_COORD, '0, 5, 5, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_DEL_NAME, NAME_ONES, 0, 0, 0, ST_DONE, '0, 0, 0, 0);
      add_row(OP_FIND_COORD, '0, COORD_MIN, COORD_MAX, 1, ST_MISS, '0, 0, 0, 0);
      add_row(OP_INSERT, 64'h8000_0000_0000_0001, 1, COORD_MIN, 0, ST_DONE,
              '0, 0, 0, 0);
      add_row(OP_DEL_COORD, 64'h1234, 1, COORD_MIN, 0, ST_DONE, '0, 0, 0, 0);

      total_items   = directed_rows.size() + RANDOM_ITEMS;
      filling       = 1'b1;
      overfill_left = $urandom_range(12, 4);

      for (item_index = 0; item_index < total_items; item_index++) begin
         // idle pattern by thirds of the run
         phase = item_index * 3 / total_items;
         case (phase)
            0:       begin req_idle_pct = 24; rsp_idle_pct = 66; end
            1:       begin req_idle_pct = 66; rsp_idle_pct = 24; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         if (item_index == 2 * total_items / 3)
            hold_off_pending = 1'b1;

         if (item_index < directed_rows.size()) begin
            row = directed_rows[item_index];
         end else begin
            row.typed = 1'b0;
            roll      = $urandom_range(99);
            if (roll < 2)
               row.op = OP_UNUSED_LO + op_type'($urandom_range(2));
            else if (roll < (filling ? 70 : 15))
               row.op = OP_INSERT;
            else if (roll < (filling ? 80 : 75))
               row.op = $urandom_range(1) ? OP_DEL_NAME : OP_DEL_COORD;
            else
               row.op = $urandom_range(1) ? OP_FIND_NAME : OP_FIND_COORD;

            row.key = pick_name();
            row.x   = pick_coord();
            row.y   = pick_coord();
            // most lookups aim at a stored record
            if (row.op != OP_INSERT && stored_count > 0 && $urandom_range(99) < 80) begin
               pick = $urandom_range(stored_count - 1);
               if (row.op == OP_DEL_NAME || row.op == OP_FIND_NAME) begin
                  row.key = shadow_records[pick].name;
               end else begin
                  row.x = shadow_records[pick].x;
                  if ($urandom_range(9) != 0)
                     row.y = shadow_records[pick].y;
               end
            end
         end

         send_word(row);

         // alternate between filling to capacity and draining to empty
         if (filling && stored_count == TABLE_DEPTH) begin
            if (overfill_left == 0)
               filling = 1'b0;
            else
               overfill_left--;
         end else if (!filling && stored_count == 0) begin
            filling       = 1'b1;
            overfill_left = $urandom_range(12, 4);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
